>>> hdl/fat_pkg.sv
// Shared types and constants for the free-list allocator.
package fat_pkg;

  localparam int BLK_W = 8;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_FIRST_FREE    = 3;

  typedef logic [BLK_W-1:0] blk_t;

  // opcodes
  localparam logic [OP_W-1:0] OP_TAKE    = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
  localparam logic [OP_W-1:0] OP_NEXT    = 3'd2;
  localparam logic [OP_W-1:0] OP_FORMAT  = 3'd3;
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_CTRL = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_DATA = 2'd2;

  typedef struct packed {
    logic            valid;
    blk_t            data_start;
    blk_t            control_block;
    logic [ST_W-1:0] status;
    blk_t            free_head;
    blk_t            free_tail;
  } result_t;

  typedef struct packed {
    logic we;
    blk_t waddr;
    blk_t wdata;
    blk_t raddr;
  } mem_req_t;

endpackage

>>> hdl/fat_ram.sv
// Generic simple dual-port RAM with registered read.
module fat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/fat_ctrl.sv
// Sequencer: formats the link RAM and walks, cuts and appends chains in it.
module fat_ctrl #(
  parameter int TABLE_ENTRIES = fat_pkg::DEF_TABLE_ENTRIES,
  parameter int FIRST_FREE    = fat_pkg::DEF_FIRST_FREE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fat_pkg::OP_W-1:0]    opcode,
  input  fat_pkg::blk_t               start_block,
  input  fat_pkg::blk_t               count,
  output fat_pkg::result_t            res,
  input  logic                        res_ready,
  output fat_pkg::mem_req_t           mem,
  input  fat_pkg::blk_t               rdata
);
  import fat_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  typedef enum logic [6:0] {
    S_FMT     = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_TAKE    = 7'b0000100,
    S_RELLINK = 7'b0001000,
    S_RELWALK = 7'b0010000,
    S_NEXT    = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  // which take is running
  localparam logic [1:0] TK_PLAIN = 2'd0;
  localparam logic [1:0] TK_CTRL  = 2'd1;
  localparam logic [1:0] TK_DATA  = 2'd2;

  function automatic logic in_range(blk_t b);
    return {1'b0, b} < (BLK_W+1)'(TABLE_ENTRIES);
  endfunction

  state_t          state, state_next;
  logic [AW-1:0]   idx, idx_next;
  logic            fmt_op, fmt_op_next;
  logic            pend, pend_next;
  logic            oor_q, oor_q_next;
  logic [1:0]      tk_kind, tk_kind_next;
  logic [AW:0]     steps, steps_next;
  blk_t            head, head_next;
  blk_t            tail, tail_next;
  blk_t            cur, cur_next;
  blk_t            first, first_next;
  blk_t            last, last_next;
  blk_t            cnt_left, cnt_left_next;
  blk_t            cnt_q, cnt_q_next;
  blk_t            ctrl_blk, ctrl_blk_next;
  blk_t            res_data, res_data_next;
  blk_t            res_ctrl, res_ctrl_next;
  logic [ST_W-1:0] res_status, res_status_next;

  blk_t link_val;
  blk_t cur_c;
  logic tk_fail;

  assign link_val = oor_q ? '0 : rdata;
  assign cur_c    = pend ? link_val : cur;
  // walk ran out of list before count, or came back to its start
  assign tk_fail  = (cnt_left != '0) ? 1'b1 : (cur_c == first);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    fmt_op_next     = fmt_op;
    pend_next       = pend;
    oor_q_next      = oor_q;
    tk_kind_next    = tk_kind;
    steps_next      = steps;
    head_next       = head;
    tail_next       = tail;
    cur_next        = cur;
    first_next      = first;
    last_next       = last;
    cnt_left_next   = cnt_left;
    cnt_q_next      = cnt_q;
    ctrl_blk_next   = ctrl_blk;
    res_data_next   = res_data;
    res_ctrl_next   = res_ctrl;
    res_status_next = res_status;
    mem.we          = 1'b0;
    mem.waddr       = last;
    mem.wdata       = '0;
    mem.raddr       = cur;

    unique case (state)
      S_FMT: begin
        mem.we    = 1'b1;
        mem.waddr = BLK_W'(idx);
        if (idx < AW'(FIRST_FREE) || idx == AW'(TABLE_ENTRIES-1)) begin
          mem.wdata = '0;
        end else begin
          mem.wdata = BLK_W'(idx) + BLK_W'(1);
        end
        if (idx == AW'(TABLE_ENTRIES-1)) begin
          head_next       = BLK_W'(FIRST_FREE);
          tail_next       = BLK_W'(TABLE_ENTRIES-1);
          res_data_next   = '0;
          res_ctrl_next   = '0;
          res_status_next = ST_OK;
          fmt_op_next     = 1'b0;
          state_next      = fmt_op ? S_RESP : S_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_data_next   = '0;
          res_ctrl_next   = '0;
          res_status_next = ST_OK;
          cur_next        = head;
          first_next      = head;
          pend_next       = 1'b0;
          cnt_q_next      = count;
          unique case (opcode)
            OP_TAKE: begin
              cnt_left_next = count;
              tk_kind_next  = TK_PLAIN;
              state_next    = S_TAKE;
            end
            OP_ALLOC: begin
              cnt_left_next = BLK_W'(1);
              tk_kind_next  = TK_CTRL;
              state_next    = S_TAKE;
            end
            OP_RELEASE: begin
              first_next = start_block;
              state_next = (count == '0) ? S_RESP : S_RELLINK;
            end
            OP_NEXT: begin
              mem.raddr  = start_block;
              oor_q_next = !in_range(start_block);
              state_next = S_NEXT;
            end
            OP_FORMAT: begin
              idx_next    = '0;
              fmt_op_next = 1'b1;
              state_next  = S_FMT;
            end
            default: state_next = S_RESP;
          endcase
        end
      end

      S_TAKE: begin
        if (cnt_left != '0 && cur_c != '0) begin
          // follow one link per cycle
          mem.raddr     = cur_c;
          oor_q_next    = !in_range(cur_c);
          last_next     = cur_c;
          cur_next      = cur_c;
          cnt_left_next = cnt_left - BLK_W'(1);
          pend_next     = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (tk_fail) begin
            case (tk_kind)
              TK_CTRL: begin
                res_status_next = ST_NO_CTRL;
                state_next      = S_RESP;
              end
              TK_DATA: begin
                // hand the control block back
                first_next      = ctrl_blk;
                res_status_next = ST_NO_DATA;
                state_next      = S_RELLINK;
              end
              default: begin
                res_status_next = ST_NO_DATA;
                state_next      = S_RESP;
              end
            endcase
          end else begin
            mem.we    = in_range(last);
            mem.waddr = last;
            mem.wdata = '0;
            head_next = cur_c;
            case (tk_kind)
              TK_CTRL: begin
                ctrl_blk_next = first;
                cur_next      = cur_c;
                first_next    = cur_c;
                cnt_left_next = cnt_q;
                tk_kind_next  = TK_DATA;
              end
              TK_DATA: begin
                res_data_next = first;
                res_ctrl_next = ctrl_blk;
                state_next    = S_RESP;
              end
              default: begin
                res_data_next = first;
                state_next    = S_RESP;
              end
            endcase
          end
        end
      end

      S_RELLINK: begin
        if (head == '0) begin
          head_next = first;
        end else begin
          mem.we    = in_range(tail);
          mem.waddr = tail;
          mem.wdata = first;
        end
        tail_next  = first;
        pend_next  = 1'b0;
        steps_next = '0;
        state_next = S_RELWALK;
      end

      S_RELWALK: begin
        if (!pend) begin
          mem.raddr  = tail;
          oor_q_next = !in_range(tail);
          pend_next  = 1'b1;
          steps_next = (AW+1)'(1);
        end else if (link_val == '0) begin
          pend_next  = 1'b0;
          state_next = S_RESP;
        end else begin
          tail_next = link_val;
          if (steps == (AW+1)'(TABLE_ENTRIES)) begin
            // cyclic chain: bounded walk
            pend_next  = 1'b0;
            state_next = S_RESP;
          end else begin
            mem.raddr  = link_val;
            oor_q_next = !in_range(link_val);
            steps_next = steps + (AW+1)'(1);
          end
        end
      end

      S_NEXT: begin
        res_data_next = link_val;
        state_next    = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_FMT;
      idx    <= '0;
      fmt_op <= 1'b0;
      pend   <= 1'b0;
      head   <= BLK_W'(FIRST_FREE);
      tail   <= BLK_W'(TABLE_ENTRIES-1);
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      fmt_op <= fmt_op_next;
      pend   <= pend_next;
      head   <= head_next;
      tail   <= tail_next;
    end
    oor_q      <= oor_q_next;
    tk_kind    <= tk_kind_next;
    steps      <= steps_next;
    cur        <= cur_next;
    first      <= first_next;
    last       <= last_next;
    cnt_left   <= cnt_left_next;
    cnt_q      <= cnt_q_next;
    ctrl_blk   <= ctrl_blk_next;
    res_data   <= res_data_next;
    res_ctrl   <= res_ctrl_next;
    res_status <= res_status_next;
  end

  assign in_ready          = (state == S_IDLE);
  assign res.valid         = (state == S_RESP);
  assign res.data_start    = res_data;
  assign res.control_block = res_ctrl;
  assign res.status        = res_status;
  assign res.free_head     = head;
  assign res.free_tail     = tail;

  a_resp_to_idle: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res_ready) |=> (state == S_IDLE))
    else $error("result handoff did not return to idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != ST_OK) |-> (res.data_start == '0 && res.control_block == '0))
    else $error("failed operation returned a block");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELWALK) |-> (steps <= (AW+1)'(TABLE_ENTRIES)))
    else $error("release walk exceeded table size");

  a_pend_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAKE && pend) |-> ($past(state) == S_TAKE))
    else $error("pending link read without a walk step");

endmodule

>>> hdl/fat_free_list_allocator.sv
// Top level: FAT free-list block allocator with stream ports.
//
// One command beat in on s_*, one result beat out on m_* for every command.
// s_tdata carries opcode, start_block and count; m_tdata carries the chosen
// blocks, a status code and the free list head and tail after the command.
// The link table lives in one RAM with a registered read; a
// sequencer follows links one per cycle by feeding the read data straight
// back as the next read address.
// What each command does between accept and its result:
//   take           walks count links from the free head and cuts them off
//   allocate file  takes one control block, then count data blocks, and
//                  hands the control block back if the data chain fails
//   release        appends the chain and walks it, at most TABLE_ENTRIES links
//   next link      reads one link;  format  sweeps the table;  other opcodes go straight to the result
// Commands are handled one at a time, bound by the link walk.
// After reset the block sweeps the whole table to its formatted
// contents with s_tready low.
// The result waits in an output register; the next command is accepted
// while it waits, and a finished result holds the sequencer until the
// output register is free.
module fat_free_list_allocator #(
  parameter int TABLE_ENTRIES = fat_pkg::DEF_TABLE_ENTRIES,
  parameter int FIRST_FREE    = fat_pkg::DEF_FIRST_FREE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // opcode[2:0], start_block[10:3], count[18:11], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // data_start[7:0], control_block[15:8], status[17:16],
                                // free_head[25:18], free_tail[33:26], zero pad
);
  import fat_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  result_t  res;
  mem_req_t mem;
  blk_t     rdata;
  logic     out_free;

  // output register payload
  blk_t            o_data, o_ctrl, o_head, o_tail;
  logic [ST_W-1:0] o_status;

  assign out_free = !m_tvalid || m_tready;

  fat_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FIRST_FREE   (FIRST_FREE)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tdata[2:0]),
    .start_block(s_tdata[10:3]),
    .count      (s_tdata[18:11]),
    .res        (res),
    .res_ready  (out_free),
    .mem        (mem),
    .rdata      (rdata)
  );

  fat_ram #(
    .WIDTH(BLK_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_links (
    .clk  (clk),
    .we   (mem.we),
    .waddr(mem.waddr[AW-1:0]),
    .wdata(mem.wdata),
    .raddr(mem.raddr[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res.valid && out_free) begin
      o_data   <= res.data_start;
      o_ctrl   <= res.control_block;
      o_status <= res.status;
      o_head   <= res.free_head;
      o_tail   <= res.free_tail;
    end
  end

  assign m_tdata = {6'b0, o_tail, o_head, o_status, o_ctrl, o_data};

endmodule
